### rtl/box_filter_downsampler_unit_macros.svh
// Assertion macros for the box filter downsampler.
// Depends on nothing; the asserting module must have clk and rst in scope.
`ifndef BOX_FILTER_DOWNSAMPLER_UNIT_MACROS_SVH
`define BOX_FILTER_DOWNSAMPLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is high
`define BFD_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset
`define BFD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFD_ASSERT_CLK(label, prop, msg)
`define BFD_ASSERT_RST(label, prop, msg)
`endif
`endif

### rtl/bfd_pkg.sv
// Shared constants, types and register codes for the box filter downsampler.
// No dependencies.
package bfd_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_SHIFT     = 3;
  localparam int CHAN          = 4;
  localparam int PIX_W         = 8;
  localparam int HSUM_W        = 11;
  localparam int BAND_W        = 14;
  localparam int SHIFT_W       = 2;
  localparam int SWIDTH_W      = 11;
  localparam int ROW_W         = 10;
  localparam int OCOL_W        = 10;
  localparam int BROW_W        = 3;

  typedef enum logic {
    REG_RESIZE_SHIFT = 1'b0,
    REG_SOURCE_WIDTH = 1'b1
  } cfg_reg_t;

  typedef logic [CHAN-1:0][PIX_W-1:0]  pix4_t;
  typedef logic [CHAN-1:0][HSUM_W-1:0] hsum4_t;
  typedef logic [CHAN-1:0][BAND_W-1:0] band4_t;

  // Per-pixel command from the position logic to the line store
  typedef struct packed {
    logic               write;
    logic               first_row;
    logic               emit;
    logic [SHIFT_W-1:0] shift;
    logic [ROW_W-1:0]   row;
    logic [OCOL_W-1:0]  ocol;
    hsum4_t             hsum;
  } acc_cmd_t;

  // Occupancy of the accumulate stage
  typedef struct packed {
    logic valid;
    logic emit;
  } s1_status_t;

  typedef struct packed {
    pix4_t             avg;
    logic [OCOL_W-1:0] ocol;
    logic [ROW_W-1:0]  row;
  } result_t;

endpackage

### rtl/bfd_ctrl.sv
// Position counters and horizontal running sum of the downsampler.
// Depends on bfd_pkg.
module bfd_ctrl
  import bfd_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [SHIFT_W-1:0]           resize_shift,
  input  logic [SWIDTH_W-1:0]          source_width,
  input  pix4_t                        pixel,
  input  logic                         start_of_frame,
  output acc_cmd_t                     cmd,
  output logic [$clog2(MAX_WIDTH)-1:0] addr
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int W_W   = COL_W + 1;
  localparam logic [BROW_W:0] ONE = 1;

  logic [COL_W-1:0]  column_count, column_count_next;
  logic [BROW_W-1:0] band_row, band_row_next;
  logic [ROW_W-1:0]  output_row_count, output_row_count_next;
  hsum4_t            horizontal_sums, horizontal_sums_next;

  logic [COL_W-1:0]   col;
  logic [BROW_W-1:0]  brow_cur;
  logic [ROW_W-1:0]   orow_cur;
  hsum4_t             hsum_cur;
  hsum4_t             hsum_new;
  logic [SHIFT_W-1:0] s;
  logic [BROW_W-1:0]  mask;
  logic [W_W-1:0]     w;
  logic [COL_W-1:0]   bc;
  logic [BROW_W-1:0]  sub_x;
  logic [BROW_W-1:0]  rb;
  logic               in_block;
  logic [W_W-1:0]     col_inc;
  logic               row_end;

  // Work out block position of the incoming pixel
  always_comb begin
    col      = start_of_frame ? '0 : column_count;
    brow_cur = start_of_frame ? '0 : band_row;
    orow_cur = start_of_frame ? '0 : output_row_count;
    hsum_cur = start_of_frame ? '0 : horizontal_sums;

    s    = (int'(resize_shift) > MAX_SHIFT) ? SHIFT_W'(MAX_SHIFT) : resize_shift;
    mask = BROW_W'((ONE << s) - ONE);

    if (source_width == '0) begin
      w = W_W'(1);
    end else if (int'(source_width) > MAX_WIDTH) begin
      w = W_W'(MAX_WIDTH);
    end else begin
      w = W_W'(source_width);
    end

    sub_x    = col[BROW_W-1:0] & mask;
    bc       = col >> s;
    rb       = brow_cur & mask;
    in_block = ({1'b0, col} < w) && ({1'b0, bc} < (w >> s));
    col_inc  = {1'b0, col} + W_W'(1);
    row_end  = (col_inc >= w);

    for (int c = 0; c < CHAN; c++) begin
      if (sub_x == '0) begin
        hsum_new[c] = HSUM_W'(pixel[c]);
      end else begin
        hsum_new[c] = hsum_cur[c] + HSUM_W'(pixel[c]);
      end
    end
  end

  // Advance counters at the row end, wrap the band at the block edge
  always_comb begin
    horizontal_sums_next  = in_block ? hsum_new : hsum_cur;
    band_row_next         = brow_cur;
    output_row_count_next = orow_cur;
    if (row_end) begin
      column_count_next = '0;
      if (rb == mask) begin
        band_row_next         = '0;
        output_row_count_next = orow_cur + ROW_W'(1);
      end else begin
        band_row_next = rb + BROW_W'(1);
      end
    end else begin
      column_count_next = col_inc[COL_W-1:0];
    end
  end

  // Command for the line store
  always_comb begin
    cmd.write     = in_block && (sub_x == mask);
    cmd.first_row = (rb == '0);
    cmd.emit      = in_block && (sub_x == mask) && (rb == mask);
    cmd.shift     = s;
    cmd.row       = orow_cur;
    cmd.ocol      = OCOL_W'(bc);
    cmd.hsum      = hsum_new;
    addr          = bc;
  end

  // Update state on each pixel transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      band_row         <= '0;
      output_row_count <= '0;
      horizontal_sums  <= '0;
    end else if (accept) begin
      column_count     <= column_count_next;
      band_row         <= band_row_next;
      output_row_count <= output_row_count_next;
      horizontal_sums  <= horizontal_sums_next;
    end
  end

endmodule

### rtl/bfd_band_store.sv
// Line store of per-block-column sums with the accumulate stage.
// Depends on bfd_pkg.
module bfd_band_store
  import bfd_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  acc_cmd_t                     cmd,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  logic                         s1_go,
  output s1_status_t                   status,
  output result_t                      result
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  band4_t mem [MAX_WIDTH];

  band4_t           rd_data;
  acc_cmd_t         s1_cmd;
  logic             s1_valid;
  logic [COL_W-1:0] s1_addr;
  logic             s1_fwd;
  band4_t           s1_fwd_data;
  band4_t           prev;
  band4_t           band_new;
  logic             wr_en;

  assign wr_en = s1_go && s1_cmd.write;

  // Write back the updated column sum
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= band_new;
    end
  end

  // Read the column sum for the pixel being taken in
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[addr];
    end
  end

  // Hold the stage until it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the command; bypass a write to the same column in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd      <= cmd;
      s1_addr     <= addr;
      s1_fwd      <= wr_en && (s1_addr == addr);
      s1_fwd_data <= band_new;
    end
  end

  // Accumulate into the column and scale down to the mean
  always_comb begin
    prev = s1_fwd ? s1_fwd_data : rd_data;
    for (int c = 0; c < CHAN; c++) begin
      if (s1_cmd.first_row) begin
        band_new[c] = BAND_W'(s1_cmd.hsum[c]);
      end else begin
        band_new[c] = prev[c] + BAND_W'(s1_cmd.hsum[c]);
      end
      result.avg[c] = PIX_W'(band_new[c] >> {s1_cmd.shift, 1'b0});
    end
    result.ocol   = s1_cmd.ocol;
    result.row    = s1_cmd.row;
    status.valid  = s1_valid;
    status.emit   = s1_cmd.emit;
  end

endmodule

### rtl/box_filter_downsampler_unit.sv
// Top level of the box filter downsampler: config registers and result register.
// Depends on bfd_pkg, bfd_ctrl, bfd_band_store and the assertion macros header.
//
//   channel   direction  handshake              payload
//   pixel     in         pixel_valid/stall      red green blue alpha start_of_frame
//   result    out        result_valid/stall     avg_* out_column out_row
//   cfg       in         cfg_valid/cfg_ready    cfg_index cfg_data
//
// One pixel per clock; result_valid rises when the bottom-right pixel of its block moves
// from the accumulate stage into the result register. Each line store entry is read on
// transfer and written back when the stage moves on; a bypass covers the same column.
// Reset clears counters and handshake state; the line store needs no clearing pass.
// A stalled result holds an accumulate stage that finishes a block, which then stalls the pixel input.
`include "box_filter_downsampler_unit_macros.svh"

module box_filter_downsampler_unit
  import bfd_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  logic [PIX_W-1:0]    red,
  input  logic [PIX_W-1:0]    green,
  input  logic [PIX_W-1:0]    blue,
  input  logic [PIX_W-1:0]    alpha,
  input  logic                start_of_frame,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [PIX_W-1:0]    avg_red,
  output logic [PIX_W-1:0]    avg_green,
  output logic [PIX_W-1:0]    avg_blue,
  output logic [PIX_W-1:0]    avg_alpha,
  output logic [OCOL_W-1:0]   out_column,
  output logic [ROW_W-1:0]    out_row,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [SWIDTH_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [SHIFT_W-1:0]  resize_shift;
  logic [SWIDTH_W-1:0] source_width;

  logic             accept;
  logic             out_load_ok;
  logic             s1_go;
  pix4_t            pixel;
  acc_cmd_t         cmd;
  logic [COL_W-1:0] addr;
  s1_status_t       status;
  result_t          result;

  assign pixel = {alpha, blue, green, red};

  // Handshake: the stage moves on unless its result cannot be loaded
  assign out_load_ok = !result_valid || !result_stall;
  assign s1_go       = status.valid && (!status.emit || out_load_ok);
  assign pixel_stall = status.valid && !s1_go;
  assign accept      = pixel_valid && !pixel_stall;
  assign cfg_ready   = 1'b1;

  // Config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      resize_shift <= SHIFT_W'(1);
      source_width <= SWIDTH_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_RESIZE_SHIFT: resize_shift <= cfg_data[SHIFT_W-1:0];
        REG_SOURCE_WIDTH: source_width <= cfg_data;
        default: ;
      endcase
    end
  end

  bfd_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .resize_shift  (resize_shift),
    .source_width  (source_width),
    .pixel         (pixel),
    .start_of_frame(start_of_frame),
    .cmd           (cmd),
    .addr          (addr)
  );

  bfd_band_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_band_store (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .cmd   (cmd),
    .addr  (addr),
    .s1_go (s1_go),
    .status(status),
    .result(result)
  );

  // Result register: load on a finished block, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && status.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && status.emit) begin
      avg_red    <= result.avg[0];
      avg_green  <= result.avg[1];
      avg_blue   <= result.avg[2];
      avg_alpha  <= result.avg[3];
      out_column <= result.ocol;
      out_row    <= result.row;
    end
  end

  `BFD_ASSERT_RST(a_reset_clears_result, rst |=> !result_valid, "result valid after reset")
  `BFD_ASSERT_CLK(a_result_from_stage, $rose(result_valid) |-> $past(status.valid && status.emit), "result without a finished block")
  `BFD_ASSERT_CLK(a_load_on_emit, (s1_go && status.emit) |=> result_valid, "finished block not loaded")

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for box_filter_downsampler_unit: directed table, then random phases.
// Depends on bfd_pkg and the downsampler RTL; an internal block-mean predictor checks results.

module tb_top;
  import bfd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES = 7;

  typedef enum logic {
    ROW_CONFIG = 1'b0,
    ROW_PIXEL  = 1'b1
  } row_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic             sof;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [PIX_W-1:0]  alpha;
    logic [OCOL_W-1:0] col;
    logic [ROW_W-1:0]  row;
  } block_mean_t;

  typedef struct packed {
    row_kind_t           kind;
    cfg_reg_t            reg_idx;
    logic [SWIDTH_W-1:0] data;
    pixel_t              px;
    logic                known;
    block_mean_t         mean;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  logic [PIX_W-1:0] red = '0;
  logic [PIX_W-1:0] green = '0;
  logic [PIX_W-1:0] blue = '0;
  logic [PIX_W-1:0] alpha = '0;
  logic start_of_frame = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [PIX_W-1:0] avg_red;
  logic [PIX_W-1:0] avg_green;
  logic [PIX_W-1:0] avg_blue;
  logic [PIX_W-1:0] avg_alpha;
  logic [OCOL_W-1:0] out_column;
  logic [ROW_W-1:0] out_row;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [SWIDTH_W-1:0] cfg_data = '0;

  // Predictor state: registers, position counters and sums
  logic [SHIFT_W-1:0]  shift_reg = 2'd1;
  logic [SWIDTH_W-1:0] width_reg = 11'd1024;
  logic [OCOL_W-1:0]   column_count = '0;
  logic [BROW_W-1:0]   band_row = '0;
  logic [ROW_W-1:0]    out_row_count = '0;
  logic [HSUM_W-1:0]   row_sums [CHAN];
  logic [BAND_W-1:0]   column_sums [DEF_MAX_WIDTH][CHAN];

  block_mean_t expected_means [$];
  stim_row_t   directed [$];

  int errors = 0;
  int pixels_sent = 0;
  int means_seen = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int sender_idle_pct = 10;
  int receiver_stall_pct = 49;

  box_filter_downsampler_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .alpha          (alpha),
    .start_of_frame (start_of_frame),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .avg_red        (avg_red),
    .avg_green      (avg_green),
    .avg_blue       (avg_blue),
    .avg_alpha      (avg_alpha),
    .out_column     (out_column),
    .out_row        (out_row),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  // Compare each result transfer with the oldest expected block mean
  always @(posedge clk) begin
    block_mean_t exp_mean;
    if (!rst && result_valid && !result_stall) begin
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual col %0d row %0d",
                 $time, out_column, out_row);
        errors++;
      end else begin
        exp_mean = expected_means.pop_front();
        means_seen++;
        check_field("avg_red", exp_mean.red, avg_red);
        check_field("avg_green", exp_mean.green, avg_green);
        check_field("avg_blue", exp_mean.blue, avg_blue);
        check_field("avg_alpha", exp_mean.alpha, avg_alpha);
        check_field("out_column", exp_mean.col, out_column);
        check_field("out_row", exp_mean.row, out_row);
      end
    end
  end

  // Advance the block-mean predictor by one pixel; queue a mean when a block closes
  task automatic predict_mean(input pixel_t px, input logic use_known, input block_mean_t known);
    int unsigned shift;
    int unsigned blk_edge;
    int unsigned width;
    int unsigned col;
    int unsigned sub_x;
    int unsigned bcol;
    int unsigned rb;
    logic [PIX_W-1:0] chan [CHAN];
    logic [PIX_W-1:0] mean [CHAN];
    logic emit;
    block_mean_t m;
    chan = '{px.red, px.green, px.blue, px.alpha};
    emit = 1'b0;
    if (px.sof) begin
      column_count = '0;
      band_row = '0;
      out_row_count = '0;
      for (int c = 0; c < CHAN; c++) row_sums[c] = '0;
    end
    shift = shift_reg;
    blk_edge = 1 << shift;
    width = width_reg;
    if (width == 0) width = 1;
    if (width > DEF_MAX_WIDTH) width = DEF_MAX_WIDTH;
    col = column_count;
    sub_x = col & (blk_edge - 1);
    bcol = col >> shift;
    rb = band_row & (blk_edge - 1);
    // Accumulate only whole block columns
    if (col < width && bcol < (width >> shift)) begin
      for (int c = 0; c < CHAN; c++) begin
        if (sub_x == 0) row_sums[c] = HSUM_W'(chan[c]);
        else row_sums[c] = row_sums[c] + HSUM_W'(chan[c]);
      end
      if (sub_x == blk_edge - 1) begin
        for (int c = 0; c < CHAN; c++) begin
          if (rb == 0) column_sums[bcol][c] = BAND_W'(row_sums[c]);
          else column_sums[bcol][c] = column_sums[bcol][c] + BAND_W'(row_sums[c]);
        end
        if (rb == blk_edge - 1) begin
          for (int c = 0; c < CHAN; c++) mean[c] = PIX_W'(column_sums[bcol][c] >> (2 * shift));
          m = {mean[0], mean[1], mean[2], mean[3], OCOL_W'(bcol), out_row_count};
          emit = 1'b1;
        end
      end
    end
    // Advance position; wrap the row at the width
    if (col + 1 >= width) begin
      column_count = '0;
      if (rb == blk_edge - 1) begin
        band_row = '0;
        out_row_count = out_row_count + 1'b1;
      end else begin
        band_row = BROW_W'(rb + 1);
      end
    end else begin
      column_count = OCOL_W'(col + 1);
    end
    if (use_known) expected_means.push_back(known);
    else if (emit) expected_means.push_back(m);
  endtask

  // Hold the pixel input until every expected mean is out, then let the pipe settle
  task automatic drain_results();
    pixel_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [SWIDTH_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_RESIZE_SHIFT) shift_reg = data[SHIFT_W-1:0];
    else width_reg = data;
    reg_writes++;
    @(posedge clk);
  endtask

  // Send one pixel with random sender gaps; predict on transfer
  task automatic send_pixel(input pixel_t px, input logic use_known, input block_mean_t known);
    if (pixels_sent < 400) begin
      sender_idle_pct = 10;
      receiver_stall_pct = 49;
    end else if (pixels_sent < 800) begin
      sender_idle_pct = 49;
      receiver_stall_pct = 10;
    end else begin
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red <= px.red;
    green <= px.green;
    blue <= px.blue;
    alpha <= px.alpha;
    start_of_frame <= px.sof;
    do @(posedge clk); while (pixel_stall);
    pixels_sent++;
    predict_mean(px, use_known, known);
  endtask

  function automatic stim_row_t reg_row(cfg_reg_t idx, logic [SWIDTH_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.reg_idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t pix_row(logic sof, logic [31:0] rgba);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PIXEL;
    r.px = {rgba, sof};
    return r;
  endfunction

  function automatic stim_row_t known_row(logic sof, logic [31:0] rgba, logic [31:0] mean_rgba,
                                          logic [OCOL_W-1:0] col, logic [ROW_W-1:0] row);
    stim_row_t r;
    r = pix_row(sof, rgba);
    r.known = 1'b1;
    r.mean = {mean_rgba, col, row};
    return r;
  endfunction

  initial begin
    int unsigned phase_shift [NUM_PHASES];
    int unsigned phase_width [NUM_PHASES];
    int unsigned phase_items [NUM_PHASES];
    pixel_t px;
    stim_row_t r;

    phase_shift = '{2, 3, 1, 0, 2, 0, 3};
    phase_width = '{8, 8, 7, 2047, 13, 0, 11};
    phase_items = '{160, 180, 150, 150, 150, 40, 200};
    for (int c = 0; c < CHAN; c++) row_sums[c] = '0;

    directed = '{
      // Pass-through with shift 0: each pixel is its own mean
      reg_row(REG_SOURCE_WIDTH, 11'd4),
      reg_row(REG_RESIZE_SHIFT, 11'd0),
      known_row(1'b1, 32'h00000000, 32'h00000000, 10'd0, 10'd0),
      known_row(1'b0, 32'hffffffff, 32'hffffffff, 10'd1, 10'd0),
      known_row(1'b0, 32'h12345678, 32'h12345678, 10'd2, 10'd0),
      known_row(1'b0, 32'habcdef01, 32'habcdef01, 10'd3, 10'd0),
      known_row(1'b0, 32'hff00ff00, 32'hff00ff00, 10'd0, 10'd1),
      // Frame restart in the middle of a row
      known_row(1'b1, 32'h5aa53cc3, 32'h5aa53cc3, 10'd0, 10'd0),
      // 2x2 blocks, odd width leaves a partial column that is dropped
      reg_row(REG_RESIZE_SHIFT, 11'h7fd),
      reg_row(REG_SOURCE_WIDTH, 11'd3),
      pix_row(1'b1, 32'hffffffff),
      pix_row(1'b0, 32'hffffffff),
      pix_row(1'b0, 32'h07070707),
      pix_row(1'b0, 32'hffffffff),
      known_row(1'b0, 32'hffffffff, 32'hffffffff, 10'd0, 10'd0),
      pix_row(1'b0, 32'h09090909),
      // Small sums truncate toward zero
      pix_row(1'b0, 32'h01020300),
      pix_row(1'b0, 32'h00000000),
      pix_row(1'b0, 32'hffffffff),
      pix_row(1'b0, 32'h00000000),
      pix_row(1'b0, 32'h02010003),
      // Width zero acts as one: narrower than a block, nothing emitted
      reg_row(REG_SOURCE_WIDTH, 11'd0),
      reg_row(REG_RESIZE_SHIFT, 11'd2),
      pix_row(1'b1, 32'h80808080),
      pix_row(1'b0, 32'h7f7f7f7f),
      // Oversized width clamps to the maximum, largest block
      reg_row(REG_SOURCE_WIDTH, 11'h7ff),
      reg_row(REG_RESIZE_SHIFT, 11'd3),
      pix_row(1'b1, 32'hffffffff),
      pix_row(1'b0, 32'h00000000)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (directed[i]) begin
      r = directed[i];
      if (r.kind == ROW_CONFIG) write_register(r.reg_idx, r.data);
      else send_pixel(r.px, r.known, r.mean);
    end

    // Random frames, one register setting per phase; each phase opens a new frame
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(REG_RESIZE_SHIFT, SWIDTH_W'(phase_shift[p]));
      write_register(REG_SOURCE_WIDTH, SWIDTH_W'(phase_width[p]));
      for (int n = 0; n < phase_items[p]; n++) begin
        if ($urandom_range(7) == 0) begin
          px.red = $urandom_range(1) ? 8'hff : 8'h00;
          px.green = $urandom_range(1) ? 8'hff : 8'h00;
          px.blue = $urandom_range(1) ? 8'hff : 8'h00;
          px.alpha = $urandom_range(1) ? 8'hff : 8'h00;
        end else begin
          px.red = PIX_W'($urandom);
          px.green = PIX_W'($urandom);
          px.blue = PIX_W'($urandom);
          px.alpha = PIX_W'($urandom);
        end
        px.sof = (n == 0) || ($urandom_range(127) == 0);
        // Hold the sender once until the result side is empty
        if (p == 1 && n == 130) drain_results();
        send_pixel(px, 1'b0, '0);
      end
    end

    drain_results();
    $display("Sent %0d pixels in %0d register settings, checked %0d block means",
             pixels_sent, reg_writes, means_seen);
    $display("Shifts 0 to 3, widths 1 to 1024, partial columns and frame restarts");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
